>>> hw/rtl/bss_pkg.sv
`timescale 1ns / 1ps

package bss_pkg;

  localparam int MIN_SAMPLES = 10;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] CFG_POINT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd1;
  localparam logic [1:0] CFG_THICKNESS    = 2'd2;

  // request to the shift-subtract unit (divide or square root)
  typedef struct packed {
    logic        start;
    logic        root;
    logic [63:0] num;    // operand, most significant bit first
    logic [31:0] den;
    logic [5:0]  steps;
  } ss_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quot;
  } ss_rsp_t;

endpackage

>>> hw/rtl/bss_shsub.sv
`timescale 1ns / 1ps

module bss_shsub (
  input  logic             clk,
  input  logic             rst_n,
  input  bss_pkg::ss_req_t req,
  output bss_pkg::ss_rsp_t rsp
);
  import bss_pkg::*;

  localparam int RW = 36;

  logic            busy_r;
  logic            done_r;
  logic            root_r;
  logic [5:0]      cnt_r;
  logic [RW-1:0]   rem_r;
  logic [47:0]     q_r;
  logic [63:0]     num_r;
  logic [31:0]     den_r;

  logic [RW-1:0]   rem_sh;
  logic [RW-1:0]   trial;
  logic [RW-1:0]   rem_nxt;
  logic            ge;

  // one quotient bit, or one root bit, per cycle
  always_comb begin
    if (root_r) begin
      rem_sh = {rem_r[RW-3:0], num_r[63:62]};
      trial  = {q_r[RW-3:0], 2'b01};
    end else begin
      rem_sh = {rem_r[RW-2:0], num_r[63]};
      trial  = {{(RW-32){1'b0}}, den_r};
    end
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        root_r <= req.root;
        num_r  <= req.num;
        den_r  <= req.den;
        cnt_r  <= req.steps;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[46:0], ge};
        num_r <= root_r ? {num_r[61:0], 2'b00} : {num_r[62:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

>>> hw/rtl/bezier_strip_sampler_core.sv
`timescale 1ns / 1ps

// Bezier strip sampler.
// Input stream: in_tuser selects a load (write one control point) or an
// evaluate (curve sample k). Loads give no result.
// An evaluate runs a sequencer over one shared 32x32 multiplier and one
// shift-subtract unit (divide and square root, one bit a cycle): the t
// division (33 steps), the Bernstein powers and sum for each control
// point, the square root (31 steps) and two normal divisions (45 steps
// each). The point count is clamped to 2..MAX_POINTS. Coincident samples
// skip the root and divisions, and sample 0 stops once its point is
// found. in_tready is low while an evaluate runs. Sample 0 gives no
// result; later samples give one vertex pair with out_tlast high, the final
// sample that pair with out_tlast low and a second pair with out_tlast high.
// Results sit in an output register; while the receiver stalls the
// sequencer holds before loading the next pair.
// Configuration writes on cfg_* are always taken and belong to idle time.
// Reset (rst_n low, synchronous) restores the register defaults and
// clears the previous point and normal; the control store is not cleared.

module bezier_strip_sampler_core #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // point_index, point_x, point_y, sample_index
  input  logic [0:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // vertex_x, vertex_y, offset_x, offset_y, vertex_sample
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bss_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = MAX_POINTS - 1;
  localparam int AW = 56;

  typedef enum logic [4:0] {
    S_IDLE, S_TDIV, S_UPM, S_UPR, S_SRD, S_W1, S_W2, S_W3, S_X, S_Y, S_TP,
    S_FIN, S_DIFF, S_DXX, S_DYY, S_M, S_SQ, S_NX, S_NY, S_OFFX, S_OFFY,
    S_OFFE, S_EMIT1, S_EMIT2
  } state_t;

  state_t state_r;

  logic [3:0]         in_point_index;
  logic [15:0]        in_point_x;
  logic [15:0]        in_point_y;
  logic [15:0]        in_sample_index;
  logic               in_operation;

  assign in_point_index  = in_tdata[3:0];
  assign in_point_x      = in_tdata[19:4];
  assign in_point_y      = in_tdata[35:20];
  assign in_sample_index = in_tdata[51:36];
  assign in_operation    = in_tuser[0];

  logic [4:0]  point_count_r;
  logic [15:0] sample_count_r;
  logic [7:0]  thickness_r;

  logic [15:0]        k_r;
  logic               final_r;
  logic [IW-1:0]      i_r;
  logic [IW-1:0]      pc_cnt_r;
  logic [CW-1:0]      row_r [MAX_POINTS];
  logic [30:0]        t30_r;
  logic [30:0]        u30_r;
  logic [30:0]        pow_r;
  logic [30:0]        w_r;
  logic signed [AW-1:0] acc_x_r;
  logic signed [AW-1:0] acc_y_r;
  logic signed [15:0] cur_x_r;
  logic signed [15:0] cur_y_r;
  logic signed [15:0] prev_x_r;
  logic signed [15:0] prev_y_r;
  logic signed [16:0] dx_r;
  logic signed [16:0] dy_r;
  logic [33:0]        m_r;
  logic [30:0]        len_r;
  logic signed [15:0] nx_r;
  logic signed [15:0] ny_r;
  logic signed [15:0] ox_r;
  logic signed [15:0] oy_r;
  logic signed [63:0] mp_r;
  ss_req_t            ss_req_r;
  ss_rsp_t            ss_rsp;

  logic               out_tvalid_r;
  logic [79:0]        out_tdata_r;
  logic               out_tlast_r;

  logic [31:0]        store_mem [MAX_POINTS];
  logic [31:0]        st_q;
  logic [30:0]        up_mem [MAX_POINTS];
  logic [30:0]        up_q;
  logic               up_we;
  logic [IW-1:0]      up_wa;
  logic [30:0]        up_wd;

  logic [15:0]        s_m1;
  logic [IW-1:0]      n_w;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic [63:0]        mp_u;
  logic [30:0]        rnd30;
  logic [32:0]        t_num;
  logic [16:0]        tq;
  logic [16:0]        dy_abs;
  logic [16:0]        dx_abs;
  logic [33:0]        m_tot;
  logic [15:0]        nmag;
  logic               ss_go;
  logic               out_load;

  bss_shsub u_shsub (
    .clk (clk),
    .rst_n (rst_n),
    .req (ss_req_r),
    .rsp (ss_rsp)
  );

  function automatic logic signed [15:0] round_q30(input logic signed [AW-1:0] a);
    logic [AW-1:0] mag;
    logic [AW-1:0] r;
    logic signed [15:0] res;
    mag = a[AW-1] ? AW'(-a) : AW'(a);
    r   = (mag + (AW'(1) << 29)) >> 30;
    if (a[AW-1]) begin
      res = (r > AW'(32768)) ? 16'sh8000 : 16'(-r);
    end else begin
      res = (r > AW'(32767)) ? 16'sh7fff : 16'(r);
    end
    return res;
  endfunction

  function automatic logic signed [15:0] round_1024(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    r   = (mag + 64'd512) >> 10;
    return p[63] ? 16'(-r) : 16'(r);
  endfunction

  function automatic logic [15:0] sat_add(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s > 17'sd32767)       return 16'h7fff;
    else if (s < -17'sd32768) return 16'h8000;
    else                      return s[15:0];
  endfunction

  always_comb begin
    if (sample_count_r < 16'(MIN_SAMPLES)) s_m1 = 16'(MIN_SAMPLES - 1);
    else                                   s_m1 = sample_count_r - 16'd1;
    if (point_count_r < 5'd2)                   n_w = IW'(1);
    else if (int'(point_count_r) > MAX_POINTS) n_w = IW'(MAX_POINTS - 1);
    else                                        n_w = IW'(point_count_r - 5'd1);
  end

  assign mp_u   = mp_r;
  assign rnd30  = mp_u[60:30] + 31'(mp_u[29]);
  assign t_num  = {1'b0, in_sample_index, 16'h0000} + 33'(s_m1 >> 1);
  assign tq     = (ss_rsp.quot > 48'd65536) ? 17'h10000 : ss_rsp.quot[16:0];
  assign dy_abs = dy_r[16] ? 17'(-dy_r) : 17'(dy_r);
  assign dx_abs = dx_r[16] ? 17'(-dx_r) : 17'(dx_r);
  assign m_tot  = m_r + mp_u[33:0];
  assign nmag   = (ss_rsp.quot > 48'd16384) ? 16'd16384 : ss_rsp.quot[15:0];

  // start the shared unit: t division, square root, then the two normal divisions
  assign ss_go = (state_r == S_IDLE && in_tvalid && in_operation == OP_EVAL) ||
                 (state_r == S_M && (dx_r != '0 || dy_r != '0)) ||
                 ((state_r == S_SQ || state_r == S_NX) && ss_rsp.done);

  assign out_load = (state_r == S_EMIT1 || state_r == S_EMIT2) &&
                    (!out_tvalid_r || out_tready);

  // operand select for the shared multiplier
  always_comb begin
    unique case (state_r)
      S_UPM:   begin mul_a = $signed({1'b0, pow_r}); mul_b = $signed({1'b0, u30_r}); end
      S_W1:    begin mul_a = $signed({1'b0, up_q});  mul_b = $signed({1'b0, pow_r}); end
      S_W2:    begin mul_a = $signed(32'(row_r[i_r])); mul_b = $signed({1'b0, rnd30}); end
      S_W3:    begin
        mul_a = $signed({1'b0, mp_u[30:0]});
        mul_b = $signed({{16{st_q[15]}}, st_q[15:0]});
      end
      S_X:     begin
        mul_a = $signed({1'b0, w_r});
        mul_b = $signed({{16{st_q[31]}}, st_q[31:16]});
      end
      S_Y:     begin mul_a = $signed({1'b0, pow_r}); mul_b = $signed({1'b0, t30_r}); end
      S_DXX:   begin
        mul_a = $signed({{15{dx_r[16]}}, dx_r});
        mul_b = $signed({{15{dx_r[16]}}, dx_r});
      end
      S_DYY:   begin
        mul_a = $signed({{15{dy_r[16]}}, dy_r});
        mul_b = $signed({{15{dy_r[16]}}, dy_r});
      end
      S_OFFX:  begin
        mul_a = $signed({24'h000000, thickness_r});
        mul_b = $signed({{16{nx_r[15]}}, nx_r});
      end
      S_OFFY:  begin
        mul_a = $signed({24'h000000, thickness_r});
        mul_b = $signed({{16{ny_r[15]}}, ny_r});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    up_we = (state_r == S_UPR) || (state_r == S_TDIV && ss_rsp.done);
    up_wa = (state_r == S_UPR) ? i_r : '0;
    up_wd = (state_r == S_UPR) ? rnd30 : ONE_Q30;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && in_operation == OP_LOAD &&
        int'(in_point_index) < MAX_POINTS) begin
      store_mem[IW'(in_point_index)] <= {in_point_y, in_point_x};
    end
    st_q <= store_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (up_we) begin
      up_mem[up_wa] <= up_wd;
    end
    up_q <= up_mem[IW'(n_w - i_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r  <= 5'd2;
      sample_count_r <= 16'd4000;
      thickness_r    <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POINT_COUNT:  point_count_r  <= cfg_data[4:0];
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_data;
        CFG_THICKNESS:    thickness_r    <= cfg_data[7:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      ss_req_r.start <= 1'b0;
      prev_x_r       <= '0;
      prev_y_r       <= '0;
      nx_r           <= '0;
      ny_r           <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      ss_req_r.start <= ss_go;
      mp_r <= prod;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_operation == OP_EVAL) begin
            k_r      <= in_sample_index;
            final_r  <= (in_sample_index >= s_m1);
            pc_cnt_r <= '0;
            for (int j = 0; j < MAX_POINTS; j++) begin
              row_r[j] <= (j == 0) ? CW'(1) : '0;
            end
            ss_req_r.root  <= 1'b0;
            ss_req_r.num   <= {t_num, 31'h0};
            ss_req_r.den   <= {16'h0000, s_m1};
            ss_req_r.steps <= 6'd33;
            state_r <= S_TDIV;
          end
        end
        S_TDIV: begin
          // build binomial row n by Pascal steps while t is divided out
          if (pc_cnt_r != n_w) begin
            for (int j = 1; j < MAX_POINTS; j++) begin
              row_r[j] <= row_r[j] + row_r[j-1];
            end
            pc_cnt_r <= pc_cnt_r + IW'(1);
          end
          if (ss_rsp.done) begin
            t30_r   <= {tq, 14'h0000};
            u30_r   <= ONE_Q30 - {tq, 14'h0000};
            pow_r   <= ONE_Q30;
            i_r     <= IW'(1);
            state_r <= S_UPM;
          end
        end
        S_UPM: state_r <= S_UPR;
        S_UPR: begin
          if (i_r == n_w) begin
            i_r     <= '0;
            pow_r   <= ONE_Q30;
            acc_x_r <= '0;
            acc_y_r <= '0;
            state_r <= S_SRD;
          end else begin
            pow_r   <= rnd30;
            i_r     <= i_r + IW'(1);
            state_r <= S_UPM;
          end
        end
        S_SRD: state_r <= S_W1;
        S_W1:  state_r <= S_W2;
        S_W2:  state_r <= S_W3;
        S_W3: begin
          w_r     <= mp_u[30:0];
          state_r <= S_X;
        end
        S_X: begin
          acc_x_r <= acc_x_r + $signed(mp_r[AW-1:0]);
          state_r <= S_Y;
        end
        S_Y: begin
          acc_y_r <= acc_y_r + $signed(mp_r[AW-1:0]);
          state_r <= S_TP;
        end
        S_TP: begin
          pow_r <= rnd30;
          if (i_r == n_w) begin
            state_r <= S_FIN;
          end else begin
            i_r     <= i_r + IW'(1);
            state_r <= S_SRD;
          end
        end
        S_FIN: begin
          cur_x_r <= round_q30(acc_x_r);
          cur_y_r <= round_q30(acc_y_r);
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          if (k_r == 16'd0) begin
            prev_x_r <= cur_x_r;
            prev_y_r <= cur_y_r;
            state_r  <= S_IDLE;
          end else begin
            dx_r    <= {cur_x_r[15], cur_x_r} - {prev_x_r[15], prev_x_r};
            dy_r    <= {cur_y_r[15], cur_y_r} - {prev_y_r[15], prev_y_r};
            state_r <= S_DXX;
          end
        end
        S_DXX: state_r <= S_DYY;
        S_DYY: begin
          m_r     <= mp_u[33:0];
          state_r <= S_M;
        end
        S_M: begin
          if (dx_r == '0 && dy_r == '0) begin
            nx_r    <= '0;
            ny_r    <= '0;
            state_r <= S_OFFX;
          end else begin
            ss_req_r.root  <= 1'b1;
            ss_req_r.num   <= {m_tot, 30'h0};
            ss_req_r.den   <= '0;
            ss_req_r.steps <= 6'd31;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (ss_rsp.done) begin
            len_r          <= ss_rsp.quot[30:0];
            ss_req_r.root  <= 1'b0;
            ss_req_r.num   <= {{dy_abs, 28'h0} + 45'(ss_rsp.quot[30:1]), 19'h0};
            ss_req_r.den   <= {1'b0, ss_rsp.quot[30:0]};
            ss_req_r.steps <= 6'd45;
            state_r <= S_NX;
          end
        end
        S_NX: begin
          if (ss_rsp.done) begin
            nx_r           <= (dy_r > 17'sd0) ? 16'(-nmag) : nmag;
            ss_req_r.root  <= 1'b0;
            ss_req_r.num   <= {{dx_abs, 28'h0} + 45'(len_r[30:1]), 19'h0};
            ss_req_r.den   <= {1'b0, len_r};
            ss_req_r.steps <= 6'd45;
            state_r <= S_NY;
          end
        end
        S_NY: begin
          if (ss_rsp.done) begin
            ny_r    <= dx_r[16] ? 16'(-nmag) : nmag;
            state_r <= S_OFFX;
          end
        end
        S_OFFX: state_r <= S_OFFY;
        S_OFFY: begin
          ox_r    <= round_1024(mp_r);
          state_r <= S_OFFE;
        end
        S_OFFE: begin
          oy_r    <= round_1024(mp_r);
          state_r <= S_EMIT1;
        end
        S_EMIT1: begin
          if (out_load) begin
            out_tdata_r  <= {k_r - 16'd1, sat_add(prev_y_r, oy_r),
                             sat_add(prev_x_r, ox_r), prev_y_r, prev_x_r};
            out_tlast_r  <= !final_r;
            prev_x_r     <= cur_x_r;
            prev_y_r     <= cur_y_r;
            state_r      <= final_r ? S_EMIT2 : S_IDLE;
          end
        end
        S_EMIT2: begin
          if (out_load) begin
            out_tdata_r  <= {k_r, sat_add(prev_y_r, oy_r),
                             sat_add(prev_x_r, ox_r), prev_y_r, prev_x_r};
            out_tlast_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_operation == OP_EVAL) |=> !in_tready)
    else $error("block still ready after taking an evaluate");

  a_row_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TDIV && ss_rsp.done) |-> (pc_cnt_r == n_w))
    else $error("binomial row not finished when t is ready");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nx_r <= 16'sd16384) && (nx_r >= -16'sd16384) &&
    (ny_r <= 16'sd16384) && (ny_r >= -16'sd16384))
    else $error("normal outside unit range");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import bss_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE = 400;
  localparam int HOLD_CYCLES = 4000;

  typedef struct {
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [15:0] smp;
    logic        lst;
  } vertex_pair_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  bezier_strip_sampler_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the block state
  logic signed [15:0] ctrl_x [16];
  logic signed [15:0] ctrl_y [16];
  logic signed [15:0] prev_x, prev_y;
  logic [4:0]         pc_reg;
  logic [15:0]        sc_reg;
  logic [7:0]         th_reg;

  vertex_pair_t pending_pairs[$];
  int err_count;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  logic hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  function automatic longint div_round(input longint num, input longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned mul_q30(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned eff_samples();
    return (sc_reg < MIN_SAMPLES) ? MIN_SAMPLES : sc_reg;
  endfunction

  function automatic void bernstein_point(input longint unsigned k, output longint px,
                                          output longint py);
    longint unsigned t_pow [16];
    longint unsigned u_pow [16];
    longint unsigned s, n, tq, t30, u30, c, w;
    longint sx, sy;
    s = eff_samples();
    n = (pc_reg < 2) ? 1 : ((pc_reg > 16) ? 15 : pc_reg - 1);
    tq = (k * 65536 + (s - 1) / 2) / (s - 1);
    if (tq > 65536) tq = 65536;
    t30 = tq << 14;
    u30 = 64'd1073741824 - t30;
    t_pow[0] = 64'd1073741824;
    u_pow[0] = 64'd1073741824;
    for (int i = 1; i <= n; i++) begin
      t_pow[i] = mul_q30(t_pow[i-1], t30);
      u_pow[i] = mul_q30(u_pow[i-1], u30);
    end
    c = 1;
    sx = 0;
    sy = 0;
    for (int i = 0; i <= n; i++) begin
      w = c * mul_q30(u_pow[n-i], t_pow[i]);
      sx += longint'(w) * longint'(ctrl_x[i]);
      sy += longint'(w) * longint'(ctrl_y[i]);
      c = c * (n - i) / (i + 1);
    end
    px = sat16(div_round(sx, 64'sd1073741824));
    py = sat16(div_round(sy, 64'sd1073741824));
  endfunction

  function automatic void push_pair(input longint x, input longint y, input longint nx,
                                    input longint ny, input logic [15:0] smp,
                                    input logic lst);
    vertex_pair_t p;
    p.vx = x[15:0];
    p.vy = y[15:0];
    p.ox = 16'(sat16(x + div_round(longint'(th_reg) * nx, 1024)));
    p.oy = 16'(sat16(y + div_round(longint'(th_reg) * ny, 1024)));
    p.smp = smp;
    p.lst = lst;
    pending_pairs.push_back(p);
  endfunction

  function automatic void predict_strip(input logic op, input logic [3:0] idx,
                                        input logic signed [15:0] x,
                                        input logic signed [15:0] y, input logic [15:0] k);
    longint cx, cy, dx, dy, nx, ny, len;
    longint unsigned m;
    bit at_end;
    if (op == OP_LOAD) begin
      ctrl_x[idx] = x;
      ctrl_y[idx] = y;
      return;
    end
    bernstein_point(k, cx, cy);
    if (k == 0) begin
      prev_x = cx[15:0];
      prev_y = cy[15:0];
      return;
    end
    nx = 0;
    ny = 0;
    dx = cx - longint'(prev_x);
    dy = cy - longint'(prev_y);
    if (dx != 0 || dy != 0) begin
      m = longint'(dx * dx) + longint'(dy * dy);
      len = longint'(int_sqrt(m << 28));
      nx = div_round(-dy * (64'sd1 << 28), len);
      ny = div_round(dx * (64'sd1 << 28), len);
      if (nx > 16384) nx = 16384;
      if (nx < -16384) nx = -16384;
      if (ny > 16384) ny = 16384;
      if (ny < -16384) ny = -16384;
    end
    at_end = (k >= eff_samples() - 1);
    push_pair(prev_x, prev_y, nx, ny, k - 16'd1, !at_end);
    prev_x = cx[15:0];
    prev_y = cy[15:0];
    if (at_end) push_pair(cx, cy, nx, ny, k, 1'b1);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    err_count++;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    vertex_pair_t p;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch("unexpected pair, vertex_sample", out_tdata[79:64], 16'h0000);
      end else begin
        p = pending_pairs.pop_front();
        if (out_tdata[15:0] !== p.vx) report_mismatch("vertex_x", out_tdata[15:0], p.vx);
        if (out_tdata[31:16] !== p.vy) report_mismatch("vertex_y", out_tdata[31:16], p.vy);
        if (out_tdata[47:32] !== p.ox) report_mismatch("offset_x", out_tdata[47:32], p.ox);
        if (out_tdata[63:48] !== p.oy) report_mismatch("offset_y", out_tdata[63:48], p.oy);
        if (out_tdata[79:64] !== p.smp)
          report_mismatch("vertex_sample", out_tdata[79:64], p.smp);
        if (out_tlast !== p.lst) report_mismatch("last", 16'(out_tlast), 16'(p.lst));
      end
    end
    out_tready <= (hold_left > 0) ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_item(input logic op, input logic [3:0] idx, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] k);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, k, y, x, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_strip(op, idx, x, y, k);
  endtask

  task automatic load_point(input int idx, input logic [15:0] x, input logic [15:0] y);
    send_item(OP_LOAD, idx[3:0], x, y, 16'($urandom));
  endtask

  task automatic eval_sample(input int k);
    send_item(OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), k[15:0]);
  endtask

  // hold the input and let every outstanding pair arrive
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_POINT_COUNT:  pc_reg = val[4:0];
      CFG_SAMPLE_COUNT: sc_reg = val;
      CFG_THICKNESS:    th_reg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int pc, input int sc, input int th);
    write_reg(CFG_POINT_COUNT, 16'(pc));
    write_reg(CFG_SAMPLE_COUNT, 16'(sc));
    write_reg(CFG_THICKNESS, 16'(th));
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(16, 10, 255);
    for (int i = 0; i < 16; i++)
      load_point(i, (i % 2) ? 16'h8000 : 16'h7fff, (i % 3) ? 16'h7fff : 16'h8000);
    for (int k = 0; k < 10; k++) eval_sample(k);
    eval_sample(4);       // out of order
    eval_sample(65535);   // beyond the end
    drain();
  endtask

  // equal points give zero normals; odd register values act clamped
  task automatic test_clamped_config();
    configure(0, 0, 0);
    load_point(0, 16'h0123, 16'hfedc);
    load_point(1, 16'h0123, 16'hfedc);
    for (int k = 0; k < 11; k++) eval_sample(k);
    drain();
    configure(31, 9, 128);
    for (int k = 0; k < 10; k++) eval_sample(k);
    drain();
    configure(1, 65535, 1);
    eval_sample(0);
    eval_sample(32767);
    eval_sample(65534);
    drain();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int n_items);
    int sent, s, top, n_loads;
    int pick;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    pick = $urandom_range(0, 5);
    case (pick)
      0: s = 10;
      1: s = 65535;
      2: s = $urandom_range(0, 9);
      3: s = $urandom;
      default: s = $urandom_range(11, 40);
    endcase
    configure($urandom_range(0, 31), s, ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255));
    s = eff_samples();
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 2) begin
        if ($urandom_range(0, 1)) load_point($urandom_range(0, 15), $urandom, $urandom);
        else eval_sample($urandom_range(0, 65535));
        sent++;
      end else begin
        n_loads = $urandom_range(0, 3);
        for (int i = 0; i < n_loads; i++) begin
          load_point($urandom_range(0, 15), $urandom, $urandom);
          sent++;
        end
        top = (s <= 40) ? s - 1 : 12;
        for (int k = 0; k <= top; k++) begin
          eval_sample(k);
          sent++;
        end
        if (s > 40) begin
          eval_sample($urandom_range(13, s - 2));
          eval_sample(s - 1);
          sent += 2;
        end
        if ($urandom_range(0, 3) == 0) begin
          eval_sample(s - 1 + $urandom_range(0, 3));
          sent++;
        end
      end
    end
    drain();
  endtask

  // stall the output long enough that the block stops taking input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(4, 12, 20);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int k = 0; k < 14; k++) eval_sample(k);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_LOAD;
    cfg_valid = 1'b0;
    cfg_index = CFG_POINT_COUNT;
    cfg_data = '0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    prev_x = 0;
    prev_y = 0;
    pc_reg = 5'd2;
    sc_reg = 16'd4000;
    th_reg = 8'd3;
    for (int i = 0; i < 16; i++) begin
      ctrl_x[i] = 0;
      ctrl_y[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_clamped_config();
    test_random_phase(0, 0, 130);
    test_random_phase(69, 0, 130);
    test_random_phase(0, 69, 130);
    test_random_phase(32, 32, 130);
    test_backpressure();
    test_random_phase(0, 0, 80);
    test_random_phase(32, 32, 80);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
